[design/lsfd_pkg.sv]
// lsfd_pkg: shared types and constants for the led strip frame driver
// no dependencies; imported by lsfd_store and led_strip_frame_driver_unit
package lsfd_pkg;

	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] OFF_BYTE = 8'h80;

	// request codes carried in s_tuser
	typedef enum logic [2:0] {
		REQ_SET     = 3'd0,
		REQ_UPDATE  = 3'd1,
		REQ_CLEAR   = 3'd2,
		REQ_DISABLE = 3'd3,
		REQ_ENABLE  = 3'd4
	} req_t;

	// control strobes from the sequencer to the pixel store
	typedef struct packed {
		logic wr;
		logic rd;
		logic clr;
	} store_ctl_t;

endpackage

[design/led_strip_frame_driver_unit.sv]
// led_strip_frame_driver_unit: top level, command decode and frame streaming
// depends on lsfd_pkg and lsfd_store
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: index, red, green, blue
// m_*      out  m_tvalid/m_tready  m_tdata: strip_byte; m_tlast: frame_end
//
// a frame is 3*NUM_LEDS color bytes and then the latch bytes, one byte per cycle while the
// output is not stalled, out of the pixel memory port
// clear and disable wipe the store at once through per-pixel valid bits
// a stalled output holds the sequencer; no command is taken while streaming
// arst_n resets to enabled with every pixel off
module led_strip_frame_driver_unit #(
	parameter int NUM_LEDS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // strip_byte[7:0]
	output logic        m_tlast
);
	import lsfd_pkg::*;

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int LATCH_BYTES = (NUM_LEDS + 31) / 32;
	localparam int LW = (LATCH_BYTES > 1) ? $clog2(LATCH_BYTES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT,
		ST_LATCH
	} state_t;

	state_t             state_q;
	logic               en_q;
	logic [AW-1:0]      pix_q;
	logic [1:0]         sel_q;
	logic [LW-1:0]      lat_q;
	logic               out_vld_q;
	logic [BYTE_W-1:0]  out_data_q;
	logic               out_last_q;

	store_ctl_t          st_ctl;
	logic [AW-1:0]       rd_addr;
	logic [3*BYTE_W-1:0] rd_word;
	logic [3*BYTE_W-1:0] wr_word;
	logic [BYTE_W-1:0]   emit_byte;

	logic       acc;
	logic       slot_free;
	logic       emit_go;
	logic [5:0] in_idx;
	logic       idx_ok;
	logic       last_pix;

	assign s_tready  = (state_q == ST_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign slot_free = !out_vld_q || m_tready;
	assign emit_go   = slot_free && (state_q == ST_EMIT || state_q == ST_LATCH);
	assign in_idx    = s_tdata[5:0];
	assign idx_ok    = (in_idx < 6'(NUM_LEDS));
	assign last_pix  = (pix_q == AW'(NUM_LEDS - 1));
	assign wr_word   = {s_tdata[29:22] | OFF_BYTE, s_tdata[13:6] | OFF_BYTE,
		s_tdata[21:14] | OFF_BYTE};

	// store strobes and read address
	always_comb begin
		st_ctl  = '0;
		rd_addr = '0;
		if (acc && en_q) begin
			case (s_tuser)
				REQ_SET:                 st_ctl.wr  = idx_ok;
				REQ_CLEAR, REQ_DISABLE:  st_ctl.clr = 1'b1;
				default:                 st_ctl     = '0;
			endcase
		end
		if (state_q == ST_FETCH) begin
			st_ctl.rd = 1'b1;
		end else if (state_q == ST_EMIT && slot_free && sel_q == 2'd2 && !last_pix) begin
			st_ctl.rd = 1'b1;
			rd_addr   = pix_q + AW'(1);
		end
		if (state_q == ST_FETCH) begin
			rd_addr = pix_q;
		end
	end

	// byte of the current pixel word
	always_comb begin
		case (sel_q)
			2'd0:    emit_byte = rd_word[7:0];
			2'd1:    emit_byte = rd_word[15:8];
			2'd2:    emit_byte = rd_word[23:16];
			default: emit_byte = OFF_BYTE;
		endcase
	end

	lsfd_store #(
		.NUM_LEDS(NUM_LEDS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(st_ctl),
		.wr_addr(in_idx[AW-1:0]),
		.wr_word(wr_word),
		.rd_addr(rd_addr),
		.rd_word(rd_word)
	);

	// command decode, frame sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			en_q       <= 1'b1;
			pix_q      <= '0;
			sel_q      <= '0;
			lat_q      <= '0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready && !emit_go) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pix_q <= '0;
					sel_q <= '0;
					lat_q <= '0;
					if (acc) begin
						case (s_tuser)
							REQ_UPDATE, REQ_CLEAR: begin
								if (en_q) state_q <= ST_FETCH;
							end
							REQ_DISABLE: begin
								en_q    <= 1'b0;
								state_q <= ST_FETCH;
							end
							REQ_ENABLE: en_q <= 1'b1;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= emit_byte;
						out_last_q <= 1'b0;
						if (sel_q == 2'd2) begin
							sel_q <= '0;
							if (last_pix) begin
								state_q <= ST_LATCH;
							end else begin
								pix_q <= pix_q + AW'(1);
							end
						end else begin
							sel_q <= sel_q + 2'd1;
						end
					end
				end
				ST_LATCH: begin
					if (slot_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= '0;
						out_last_q <= (lat_q == LW'(LATCH_BYTES - 1));
						if (lat_q == LW'(LATCH_BYTES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							lat_q <= lat_q + LW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// an update while enabled starts a frame fetch
	a_update_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser == REQ_UPDATE && en_q) |=> (state_q == ST_FETCH))
		else $error("update did not start a frame");

	// the frame end byte is a zero latch byte
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata == '0))
		else $error("frame end on a non-latch byte");

	// store writes only happen between frames
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_ctl.wr || st_ctl.clr) |-> (state_q == ST_IDLE))
		else $error("store changed during a frame");

	// latch bytes only follow the color bytes
	a_latch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LATCH) |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_LATCH))
		else $error("latch phase entered out of order");

endmodule

[design/lsfd_store.sv]
// lsfd_store: pixel memory, one 24-bit word per led (green low, blue high)
// per-pixel valid bits give the off value after reset or a clear
// depends on lsfd_pkg
module lsfd_store #(
	parameter int NUM_LEDS = 18,
	parameter int AW = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsfd_pkg::store_ctl_t     ctl,
	input  logic [AW-1:0]            wr_addr,
	input  logic [3*lsfd_pkg::BYTE_W-1:0] wr_word,
	input  logic [AW-1:0]            rd_addr,
	output logic [3*lsfd_pkg::BYTE_W-1:0] rd_word
);
	import lsfd_pkg::*;

	logic [3*BYTE_W-1:0] mem [NUM_LEDS];
	logic [NUM_LEDS-1:0] valid_q;
	logic [3*BYTE_W-1:0] rd_word_q;
	logic                rd_vld_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_word;
		end
		if (ctl.rd) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// valid bits, cleared all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// pixels not written since reset or a clear read as off
	assign rd_word = rd_vld_q ? rd_word_q : {3{OFF_BYTE}};

endmodule

[tb/sv/led_strip_frame_driver_unit_tb.sv]
`timescale 1ns / 1ps
// led_strip_frame_driver_unit_tb: self-checking bench for the led strip frame driver
// depends on lsfd_pkg and led_strip_frame_driver_unit; a frame buffer predictor checks every byte
module led_strip_frame_driver_unit_tb;
	import lsfd_pkg::*;

	localparam int LED_COUNT = 18;
	localparam int COLOR_BYTES = 3 * LED_COUNT;
	localparam int LATCH_BYTES = (LED_COUNT + 31) / 32;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 188;
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_CYCLES = 400;
	localparam int STALL_AFTER_BYTES = 300;
	localparam int IDLE_PCT = 9;

	// request codes the block has no use for
	localparam logic [2:0] REQ_SPARE5 = 3'd5;
	localparam logic [2:0] REQ_SPARE6 = 3'd6;
	localparam logic [2:0] REQ_SPARE7 = 3'd7;

	typedef struct packed {
		logic [7:0] strip_byte;
		logic       frame_end;
	} strip_out_t;

	// typed: expectation given in the row, frame says whether an all-off frame follows
	typedef struct packed {
		logic [2:0] req;
		logic [5:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       typed;
		logic       frame;
	} cmd_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam cmd_row_t CMD_TABLE [DIRECTED_ROWS] = '{
		'{REQ_UPDATE,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
		'{REQ_SET,     6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
		'{REQ_SET,     6'd17, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0},
		'{REQ_SET,     6'd18, 8'h11, 8'h22, 8'h33, 1'b1, 1'b0},
		'{REQ_SET,     6'd63, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0},
		'{REQ_SET,     6'd5,  8'h7f, 8'h01, 8'h80, 1'b0, 1'b0},
		'{REQ_SET,     6'd42, 8'h55, 8'haa, 8'h55, 1'b1, 1'b0},
		'{REQ_UPDATE,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
		'{REQ_SPARE5,  6'd1,  8'hff, 8'hff, 8'hff, 1'b1, 1'b0},
		'{REQ_SPARE6,  6'd2,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
		'{REQ_SPARE7,  6'd63, 8'ha5, 8'h5a, 8'hc3, 1'b1, 1'b0},
		'{REQ_UPDATE,  6'd63, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0},
		'{REQ_CLEAR,   6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
		'{REQ_SET,     6'd9,  8'h12, 8'h34, 8'h56, 1'b0, 1'b0},
		'{REQ_DISABLE, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
		'{REQ_SET,     6'd2,  8'h7e, 8'h3c, 8'h18, 1'b1, 1'b0},
		'{REQ_UPDATE,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
		'{REQ_CLEAR,   6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
		'{REQ_DISABLE, 6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
		'{REQ_ENABLE,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
		'{REQ_ENABLE,  6'd0,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
		'{REQ_SET,     6'd3,  8'h01, 8'h02, 8'h03, 1'b0, 1'b0},
		'{REQ_UPDATE,  6'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
	logic [2:0]  s_tuser;   // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // strip_byte[7:0]
	logic        m_tlast;

	// predicted frame buffer and enable flag
	logic [7:0]  pixel_bytes [COLOR_BYTES];
	logic        strip_on;

	strip_out_t  bytes_due [$];
	int unsigned fail_count = 0;
	int unsigned bytes_seen = 0;
	bit          quiet_tx = 1'b0;

	led_strip_frame_driver_unit #(
		.NUM_LEDS(LED_COUNT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// frame buffer predictor: updates state, tells whether a frame goes out
	function automatic void model_request(input logic [2:0] req, input logic [5:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			output bit streams);
		int base;
		int k;
		streams = 1'b0;
		case (req)
			REQ_SET: begin
				if (strip_on && idx < LED_COUNT) begin
					base = int'(idx) * 3;
					pixel_bytes[base]     = green | OFF_BYTE;
					pixel_bytes[base + 1] = red | OFF_BYTE;
					pixel_bytes[base + 2] = blue | OFF_BYTE;
				end
			end
			REQ_UPDATE: begin
				streams = strip_on;
			end
			REQ_CLEAR: begin
				if (strip_on) begin
					for (k = 0; k < COLOR_BYTES; k++) pixel_bytes[k] = OFF_BYTE;
					streams = 1'b1;
				end
			end
			REQ_DISABLE: begin
				if (strip_on)
					for (k = 0; k < COLOR_BYTES; k++) pixel_bytes[k] = OFF_BYTE;
				strip_on = 1'b0;
				streams = 1'b1;
			end
			REQ_ENABLE: begin
				strip_on = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// queue one frame: the predicted buffer, or every pixel off
	function automatic void queue_frame(input bit all_off);
		strip_out_t entry;
		int k;
		for (k = 0; k < COLOR_BYTES; k++) begin
			entry.strip_byte = all_off ? OFF_BYTE : pixel_bytes[k];
			entry.frame_end = 1'b0;
			bytes_due.push_back(entry);
		end
		for (k = 0; k < LATCH_BYTES; k++) begin
			entry.strip_byte = 8'h00;
			entry.frame_end = (k == LATCH_BYTES - 1);
			bytes_due.push_back(entry);
		end
	endfunction

	// offer one command, with random gaps, and predict it once the transaction completes
	task automatic send_cmd(input logic [2:0] req, input logic [5:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			output bit streams);
		while (!quiet_tx && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {2'b00, blue, green, red, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model_request(req, idx, red, green, blue, streams);
	endtask

	// command side: directed table, then random traffic
	initial begin : cmd_source
		int unsigned row;
		int unsigned counted;
		int unsigned pick;
		logic [2:0] req;
		logic [5:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit streams;
		int k;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		for (k = 0; k < COLOR_BYTES; k++) pixel_bytes[k] = OFF_BYTE;
		strip_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed commands
		for (row = 0; row < DIRECTED_ROWS; row++) begin
			send_cmd(CMD_TABLE[row].req, CMD_TABLE[row].idx, CMD_TABLE[row].red,
				CMD_TABLE[row].green, CMD_TABLE[row].blue, streams);
			if (CMD_TABLE[row].typed) begin
				if (CMD_TABLE[row].frame) queue_frame(1'b1);
			end else if (streams) begin
				queue_frame(1'b0);
			end
		end

		// random commands, mostly pixel writes, mixed with updates, clears, disables, enables and spare codes
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			quiet_tx = (counted >= 60 && counted < 110);
			pick = $urandom_range(0, 99);
			idx = 6'($urandom_range(0, LED_COUNT - 1));
			red = 8'($urandom);
			green = 8'($urandom);
			blue = 8'($urandom);
			if (pick < 55) begin
				req = REQ_SET;
				if ($urandom_range(0, 6) == 0) idx = 6'($urandom_range(LED_COUNT, 63));
			end else if (pick < 72) begin
				req = REQ_UPDATE;
			end else if (pick < 78) begin
				req = REQ_CLEAR;
			end else if (pick < 85) begin
				req = REQ_DISABLE;
			end else if (pick < 95) begin
				req = REQ_ENABLE;
			end else begin
				req = 3'($urandom_range(REQ_SPARE5, REQ_SPARE7));
				idx = 6'($urandom);
			end
			send_cmd(req, idx, red, green, blue, streams);
			if (streams) queue_frame(1'b0);
			counted++;
		end
		s_tvalid <= 1'b0;
		quiet_tx = 1'b0;

		// wait for the last frame, then a little longer for stray bytes
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && bytes_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// strip side: check every byte transaction, random back-pressure, one long hold
	initial begin : strip_sink
		strip_out_t want;
		int unsigned cycle_count;
		int unsigned hold_left;
		bit hold_done;
		bit quiet_rx;

		cycle_count = 0;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_count++;
			if (m_tvalid && m_tready) begin
				if (bytes_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected byte %02h last %0b at %0t", m_tdata, m_tlast, $time);
				end else begin
					want = bytes_due.pop_front();
					if (want.strip_byte !== m_tdata || want.frame_end !== m_tlast) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("byte %0d: expected %02h last %0b, got %02h last %0b",
								bytes_seen, want.strip_byte, want.frame_end, m_tdata, m_tlast);
					end
				end
				bytes_seen++;
			end
			quiet_rx = (cycle_count >= 2500 && cycle_count < 4000);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && bytes_seen >= STALL_AFTER_BYTES) begin
				hold_done = 1'b1;
				hold_left = STALL_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet_rx || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// run limit
	initial begin : run_limit
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
